// ===== rtl/core/asws_pkg.sv =====
package asws_pkg;

    // Width of every scaled value (m/s^2, -19..19, two's complement)
    localparam int VAL_W = 6;

    // Width of the assembled sensor sample
    localparam int RAW_W = 12;

    // |raw| * 49 / 5120 == (|raw| * SCALE_RECIP) >> SCALE_SHIFT for |raw| <= 2048
    localparam int                SCALE_SHIFT = 24;
    localparam logic [17:0]       SCALE_RECIP = 18'd160564;

    typedef logic signed [VAL_W-1:0] val_t;

    // One result beat
    typedef struct packed {
        logic done;
        val_t high;
        val_t low;
        val_t avg;
        val_t scaled;
    } res_t;

endpackage

// ===== rtl/core/asws_scale.sv =====
module asws_scale (
    input  logic                         aclk,
    input  logic                         step,
    input  logic [asws_pkg::RAW_W-1:0]   raw_i,
    output asws_pkg::val_t               v_o
);
    import asws_pkg::*;

    logic             neg;
    logic [RAW_W-1:0] mag;
    logic [29:0]      prod;
    logic [4:0]       quo;
    val_t             v_next;
    val_t             v_reg;

    // Sign-magnitude constant multiply, truncation toward zero
    always_comb begin
        neg    = raw_i[RAW_W-1];
        mag    = neg ? (~raw_i + 1'b1) : raw_i;
        prod   = 30'(mag) * 30'(SCALE_RECIP);
        quo    = prod[SCALE_SHIFT+4:SCALE_SHIFT];
        v_next = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            v_reg <= v_next;
        end
    end

    assign v_o = v_reg;

endmodule

// ===== rtl/core/asws_stats.sv =====
module asws_stats #(
    parameter int WINDOW_LEN = 20,
    parameter int AVG_LEN    = 5
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  asws_pkg::val_t  v_i,
    output asws_pkg::res_t  res_o
);
    import asws_pkg::*;

    localparam int SUM_W   = $clog2(19 * AVG_LEN + 1) + 1;
    localparam int MAG_W   = SUM_W - 1;
    localparam int SLOT_W  = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
    localparam int FILL_W  = $clog2(WINDOW_LEN);
    localparam int RECIP_K = 16;
    localparam logic [RECIP_K:0] RECIP = (RECIP_K+1)'(((1 << RECIP_K) + AVG_LEN - 1) / AVG_LEN);
    localparam int PROD_W  = MAG_W + RECIP_K + 1;

    val_t                    ring_reg [AVG_LEN];
    logic signed [SUM_W-1:0] sum_reg, sum_next, sum_base;
    logic [SLOT_W-1:0]       slot_reg, slot_next, slot_cur;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    val_t                    low_reg, low_next;
    val_t                    high_reg, high_next;
    res_t                    res_reg, res_next;

    logic                    start;
    logic                    done;
    val_t                    old;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [VAL_W-2:0]        quo;
    val_t                    avg;

    // Window bookkeeping, running sum and min/max
    always_comb begin
        start     = (fill_reg == '0);
        done      = (fill_reg == FILL_W'(WINDOW_LEN - 1));
        fill_next = done ? '0 : fill_reg + 1'b1;

        slot_cur  = start ? '0 : slot_reg;
        slot_next = (slot_cur == SLOT_W'(AVG_LEN - 1)) ? '0 : slot_cur + 1'b1;

        // entries not yet written in this window count as zero
        old       = (32'(fill_reg) < AVG_LEN) ? val_t'(0) : ring_reg[slot_cur];
        sum_base  = start ? '0 : sum_reg;
        sum_next  = sum_base - SUM_W'(old) + SUM_W'(v_i);

        // divide by AVG_LEN toward zero via reciprocal
        mag       = sum_next[SUM_W-1] ? MAG_W'(-sum_next) : MAG_W'(sum_next);
        prod      = PROD_W'(mag) * PROD_W'(RECIP);
        quo       = prod[RECIP_K+VAL_W-2:RECIP_K];
        avg       = sum_next[SUM_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

        low_next  = (start || v_i < low_reg)  ? v_i : low_reg;
        high_next = (start || v_i > high_reg) ? v_i : high_reg;

        res_next.scaled = v_i;
        res_next.avg    = avg;
        res_next.low    = low_next;
        res_next.high   = high_next;
        res_next.done   = done;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            slot_reg <= '0;
            sum_reg  <= '0;
            low_reg  <= val_t'(31);
            high_reg <= val_t'(-32);
        end else if (step) begin
            fill_reg <= fill_next;
            slot_reg <= slot_next;
            sum_reg  <= sum_next;
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    // Ring entries and result beat
    always_ff @(posedge aclk) begin
        if (step) begin
            ring_reg[slot_cur] <= v_i;
            res_reg            <= res_next;
        end
    end

    assign res_o = res_reg;

endmodule

// ===== rtl/core/accel_sample_window_stats_unit.sv =====
// Accelerometer sample window statistics, one axis per instance.
// Input stream: each beat carries the axis's high and low data bytes; the
// 12-bit sample is {msb_byte, lsb_byte[7:4]}. Output stream: one beat per
// input beat with the value in m/s^2 (truncated toward zero), the moving
// average of the last AVG_LEN samples of the window, the window's running
// min and max, and a tuser flag on the WINDOW_LEN-th sample of a window.
// Path: an accepted beat moves from the input register to the scale
// register and then to the result register on the master side.
// Throughput: one beat per cycle while the sink keeps m_tready high;
// the per-beat state update (sum, slot, window count, min/max) closes
// in the single result stage.
// Each register stage has its own valid bit, so empty stages still take
// data while a finished result waits on m_tready; with all three stages
// full, s_tready drops until the sink takes a beat.
// Reset: synchronous, active low. It empties the pipe and starts a fresh
// window; no clearing pass is needed.
module accel_sample_window_stats_unit #(
    parameter int WINDOW_LEN = 20,
    parameter int AVG_LEN    = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] msb_byte, [15:8] lsb_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [5:0] scaled_value, [11:6] moving_average,
                                   // [17:12] window_low, [23:18] window_high
    output logic        m_tuser    // [0] window_done
);
    import asws_pkg::*;

    logic             in_vld_reg, in_vld_next;
    logic             sc_vld_reg, sc_vld_next;
    logic             out_vld_reg, out_vld_next;
    logic [RAW_W-1:0] raw_reg;
    logic             step_sc, step_st, take_in;
    val_t             v;
    res_t             res;

    // Per-stage handshake: a stage advances when the next one is empty or moving
    always_comb begin
        step_st      = sc_vld_reg && (!out_vld_reg || m_tready);
        step_sc      = in_vld_reg && (!sc_vld_reg || step_st);
        s_tready     = !in_vld_reg || step_sc;
        take_in      = s_tvalid && s_tready;

        in_vld_next  = take_in ? 1'b1 : (step_sc ? 1'b0 : in_vld_reg);
        sc_vld_next  = step_sc ? 1'b1 : (step_st ? 1'b0 : sc_vld_reg);
        out_vld_next = step_st ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            sc_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            sc_vld_reg  <= sc_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Input register: assemble the 12-bit sample
    always_ff @(posedge aclk) begin
        if (take_in) begin
            raw_reg <= {s_tdata[7:0], s_tdata[15:12]};
        end
    end

    asws_scale u_scale (
        .aclk  (aclk),
        .step  (step_sc),
        .raw_i (raw_reg),
        .v_o   (v)
    );

    asws_stats #(
        .WINDOW_LEN (WINDOW_LEN),
        .AVG_LEN    (AVG_LEN)
    ) u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step_st),
        .v_i     (v),
        .res_o   (res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {res.high, res.low, res.avg, res.scaled};
    assign m_tuser  = res.done;

endmodule

// ===== rtl/core/asws_checker.sv =====
module asws_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);
    localparam logic signed [5:0] VMAX = 6'sd19;

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed under stall");

    // Reset empties the pipe
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Scaled value stays within sensor range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[5:0]) <= VMAX && $signed(m_tdata[5:0]) >= -VMAX)
        else $error("scaled value out of range");

    // Current sample lies between window min and max
    a_minmax: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[17:12]) <= $signed(m_tdata[5:0])
                  && $signed(m_tdata[5:0]) <= $signed(m_tdata[23:18]))
        else $error("window min/max does not bracket sample");

endmodule

bind accel_sample_window_stats_unit asws_checker u_asws_checker (.*);

// ===== bench/tb_top.sv =====
module tb_top;

    import asws_pkg::*;

    localparam int WIN_LEN     = 20;
    localparam int AVG_DEPTH   = 5;
    localparam int SCALE_MUL   = 196;
    localparam int SCALE_DIV   = 20480;
    localparam int VAL_MAX     = 31;
    localparam int VAL_MIN     = -32;
    localparam int HOLD_CYCLES = 120;
    localparam int IDLE_LIMIT  = 1000;
    localparam int TAIL_CYCLES = 8;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] msb_byte, [15:8] lsb_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [5:0] scaled_value, [11:6] moving_average,
                            // [17:12] window_low, [23:18] window_high
    logic        m_tuser;   // [0] window_done

    // Expected window statistics, one entry per accepted sample beat
    class window_stats_board;
        int   errors;
        int   results;
        int   windows;
        res_t stats_q[$];
        int   ring[AVG_DEPTH];
        int   ring_total;
        int   slot;
        int   fill;
        int   run_lo;
        int   run_hi;

        function new();
            foreach (ring[i]) ring[i] = 0;
            ring_total = 0;
            slot       = 0;
            fill       = 0;
            run_lo     = VAL_MAX;
            run_hi     = VAL_MIN;
            errors     = 0;
            results    = 0;
            windows    = 0;
        endfunction

        function int pending();
            return stats_q.size();
        endfunction

        // Work out the statistics one sample beat produces
        function void note_beat(logic [7:0] msb, logic [7:0] lsb);
            logic signed [RAW_W-1:0] sample;
            int   raw;
            int   mps2;
            int   mean;
            res_t stats;
            sample = {msb, lsb[7:4]};
            raw    = sample;
            mps2   = (raw * SCALE_MUL) / SCALE_DIV;
            // new window: average ring restarts empty, min/max at this sample
            if (fill == 0) begin
                foreach (ring[i]) ring[i] = 0;
                ring_total = 0;
                slot       = 0;
                run_lo     = mps2;
                run_hi     = mps2;
            end
            ring_total = ring_total - ring[slot] + mps2;
            ring[slot] = mps2;
            mean       = ring_total / AVG_DEPTH;
            slot       = (slot + 1 == AVG_DEPTH) ? 0 : slot + 1;
            if (mps2 < run_lo) run_lo = mps2;
            if (mps2 > run_hi) run_hi = mps2;
            stats.scaled = val_t'(mps2);
            stats.avg    = val_t'(mean);
            stats.low    = val_t'(run_lo);
            stats.high   = val_t'(run_hi);
            stats.done   = (fill + 1 >= WIN_LEN);
            fill         = stats.done ? 0 : fill + 1;
            stats_q.push_back(stats);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compare one result beat with the oldest expectation
        task check_result(res_t got);
            res_t want;
            if (stats_q.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            want = stats_q.pop_front();
            results++;
            if (got.done) windows++;
            if (got.scaled !== want.scaled)
                report($sformatf("beat %0d scaled_value exp %0d got %0d",
                                 results, want.scaled, got.scaled));
            if (got.avg !== want.avg)
                report($sformatf("beat %0d moving_average exp %0d got %0d",
                                 results, want.avg, got.avg));
            if (got.low !== want.low)
                report($sformatf("beat %0d window_low exp %0d got %0d",
                                 results, want.low, got.low));
            if (got.high !== want.high)
                report($sformatf("beat %0d window_high exp %0d got %0d",
                                 results, want.high, got.high));
            if (got.done !== want.done)
                report($sformatf("beat %0d window_done exp %0b got %0b",
                                 results, want.done, got.done));
        endtask

        task close();
            while (stats_q.size() != 0) begin
                void'(stats_q.pop_front());
                report("expected result beat never arrived");
            end
        endtask
    endclass

    window_stats_board board;

    // Flags shared between the sender and the sink, plus walk state and beat and idle counters
    bit calm;
    bit hold_req;
    bit hold_active;
    int walk_raw;
    int beats_sent;
    int idle_cycles;

    // Hand-picked beats {lsb, msb}: zero, full scale both ways, -1, ignored
    // low nibble, truncation edges around +-1 m/s^2, ring wrap, window end
    // at beat 20 and the next window's start
    logic [15:0] directed_beats [22] = '{
        16'h0000, 16'hF07F, 16'h0080, 16'hF0FF, 16'hFFFF, 16'h0F00,
        16'h9006, 16'h8006, 16'h70F9, 16'h80F9, 16'hFF7F, 16'h0F80,
        16'h0040, 16'h00C0, 16'h0020, 16'h00E0, 16'hA055, 16'h50AA,
        16'hF07F, 16'h0080, 16'h3412, 16'h0080
    };

    accel_sample_window_stats_unit #(
        .WINDOW_LEN (WIN_LEN),
        .AVG_LEN    (AVG_DEPTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random sample beat: uniform bytes, high bytes of zero, -1 or full scale, or a slow walk
    function automatic logic [15:0] pick_beat();
        int          r;
        int          step;
        logic [7:0]  msb;
        logic [11:0] walk;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom);
        if (r < 65) begin
            case ($urandom_range(0, 3))
                0:       msb = 8'h00;
                1:       msb = 8'h7F;
                2:       msb = 8'h80;
                default: msb = 8'hFF;
            endcase
            return {8'($urandom), msb};
        end
        step     = $urandom_range(0, 400);
        walk_raw = walk_raw + step - 200;
        if (walk_raw > 2047) walk_raw = 2047;
        if (walk_raw < -2048) walk_raw = -2048;
        walk = walk_raw[11:0];
        return {walk[3:0], 4'($urandom), walk[11:4]};
    endfunction

    // Offer one beat and wait until it is taken
    task automatic send_beat(input logic [15:0] beat);
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    // Optional idle stretch after a beat
    task automatic pace();
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_run(input int count);
        for (int i = 0; i < count; i++) begin
            send_beat(pick_beat());
            pace();
        end
    endtask

    // Sink side ready pattern, including the long hold-off on request
    initial begin
        int gap;
        m_tready <= 1'b0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                m_tready   <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // Beat monitor on both sides, plus the no-progress watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                board.check_result(res_t'({m_tuser, m_tdata}));
            if (s_tvalid && s_tready)
                board.note_beat(s_tdata[7:0], s_tdata[15:8]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Main sequence
    initial begin
        board       = new();
        calm        = 1'b0;
        hold_req    = 1'b0;
        hold_active = 1'b0;
        walk_raw    = 0;
        beats_sent  = 0;
        idle_cycles = 0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        aresetn    <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_beats[i]) begin
            send_beat(directed_beats[i]);
            pace();
        end
        send_run(700);

        // long sink hold-off while the source keeps offering back to back
        s_tvalid <= 1'b0;
        hold_req = 1'b1;
        while (!hold_active) @(posedge aclk);
        for (int i = 0; i < 12; i++)
            send_beat(pick_beat());

        // source pause until every result is back; waiting on the clock first
        // lets the monitor log the last beat
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);

        // stretch with no idling on either side
        calm = 1'b1;
        send_run(300);
        calm = 1'b0;
        send_run(970);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        board.close();

        $display("Run: %0d sample beats, %0d results checked, %0d windows closed;",
                 beats_sent, board.results, board.windows);
        $display("full-scale and truncation-edge samples, sink hold-off and drain pause.");
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== accel_sample_window_stats_unit.f =====
rtl/core/asws_pkg.sv
rtl/core/asws_scale.sv
rtl/core/asws_stats.sv
rtl/core/accel_sample_window_stats_unit.sv
rtl/core/asws_checker.sv
bench/tb_top.sv
